/* rtl/phase_accumulator_oscillator_assert.svh */
// Assertion macros for the phase accumulator oscillator.
// The macros expect signals named clk and rst_n in the scope where they are used.
`ifndef PHASE_ACCUMULATOR_OSCILLATOR_ASSERT_SVH
`define PHASE_ACCUMULATOR_OSCILLATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on every clock edge outside reset.
`define PAO_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pao assertion failed");
// Next-cycle implication, checked on every clock edge outside reset.
`define PAO_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pao assertion failed");
`else
`define PAO_ASSERT_IMPL(label, ante, cons)
`define PAO_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* rtl/pao_pkg.sv */
// Shared constants, types and the quarter-wave sine table function.
// No dependencies; used by every module of the oscillator.
`timescale 1ns / 1ps

package pao_pkg;

  localparam int PHASE_BITS      = 32;
  localparam int SINE_TABLE_BITS = 10;
  localparam int SAMPLE_BITS     = 16;

  localparam int FREQ_BITS      = 24;
  localparam int RATE_BITS      = 40;
  localparam int RATE_SPLIT     = RATE_BITS / 2;
  localparam int PROD_LO_BITS   = FREQ_BITS + RATE_SPLIT;
  localparam int PROD_HI_BITS   = FREQ_BITS + RATE_BITS - RATE_SPLIT;
  localparam int PROD_SUM_BITS  = 56;
  localparam int TABLE_N        = 1 << SINE_TABLE_BITS;
  localparam int ROM_ADDR_BITS  = SINE_TABLE_BITS + 1;
  localparam int MAG_BITS       = SAMPLE_BITS - 1;

  localparam int WAVE_BITS      = 2;
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = RATE_BITS;

  localparam logic [WAVE_BITS-1:0] WAVE_SINE     = 2'd0;
  localparam logic [WAVE_BITS-1:0] WAVE_SAW      = 2'd1;
  localparam logic [WAVE_BITS-1:0] WAVE_PULSE    = 2'd2;
  localparam logic [WAVE_BITS-1:0] WAVE_RESERVED = 2'd3;

  localparam logic [CFG_INDEX_BITS-1:0] REG_WAVEFORM   = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RATE_SCALE = 1'b1;

  localparam logic [RATE_BITS-1:0] RATE_RESET = 40'd5864062015;

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_NEG = {1'b1, {(SAMPLE_BITS-2){1'b0}}, 1'b1};

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] AMP         = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;

  // Load enables of the six pipeline stages.
  typedef struct packed {
    logic ld_freq;
    logic ld_prod;
    logic ld_inc;
    logic ld_phase;
    logic ld_shape;
    logic ld_out;
  } pao_ld_t;

  // One entry of the quarter-wave table: Q30 Taylor series of sin, scaled to
  // full amplitude with round half up. Evaluated at elaboration only.
  function automatic logic [MAG_BITS-1:0] sine_entry(int unsigned i);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        v;
    x    = (HALF_PI_Q30 * 64'(i)) / TABLE_N;
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    term = ((term * x2) >> 30) / 64'd6;   sum = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd20;  sum = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd42;  sum = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd72;  sum = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd110; sum = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd156; sum = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd210; sum = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd272; sum = sum + signed'(term);
    if (sum < 0) begin
      sum = 0;
    end
    v = (AMP * unsigned'(sum) + (64'd1 << 29)) >> 30;
    if (v > AMP) begin
      v = AMP;
    end
    return v[MAG_BITS-1:0];
  endfunction

endpackage

/* rtl/pao_sine_rom.sv */
// Quarter-wave sine table with a registered read port.
// Depends on pao_pkg for the table size and the entry function.
`timescale 1ns / 1ps

module pao_sine_rom
  import pao_pkg::*;
(
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [ROM_ADDR_BITS-1:0] rd_addr,
  output logic [MAG_BITS-1:0]      rd_data_r
);

  logic [MAG_BITS-1:0] rom_w [TABLE_N+1];

  for (genvar g = 0; g <= TABLE_N; g++) begin : g_rom
    assign rom_w[g] = sine_entry(g);
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= rom_w[rd_addr];
    end
  end

endmodule

/* rtl/pao_incr.sv */
// Phase increment pipeline: input register, two partial products, final sum.
// Depends on pao_pkg for widths and the stage load struct.
`timescale 1ns / 1ps

module pao_incr
  import pao_pkg::*;
(
  input  logic                  clk,
  input  pao_ld_t               ld,
  input  logic [FREQ_BITS-1:0]  in_freq,
  input  logic [RATE_BITS-1:0]  rate_scale,
  output logic [PHASE_BITS-1:0] inc_r
);

  logic [FREQ_BITS-1:0]     freq_r;
  logic [PROD_LO_BITS-1:0]  pp_lo_r;
  logic [PROD_LO_BITS-1:0]  pp_lo_nxt;
  logic [PROD_HI_BITS-1:0]  pp_hi_r;
  logic [PROD_HI_BITS-1:0]  pp_hi_nxt;
  logic [PROD_SUM_BITS-1:0] prod;
  logic [PHASE_BITS-1:0]    inc_nxt;

  // The 24 x 40 product is split on the rate scale into two narrower multiplies.
  assign pp_lo_nxt = PROD_LO_BITS'(freq_r) * PROD_LO_BITS'(rate_scale[RATE_SPLIT-1:0]);
  assign pp_hi_nxt = PROD_HI_BITS'(freq_r) *
                     PROD_HI_BITS'(rate_scale[RATE_BITS-1:RATE_SPLIT]);

  // Bits above the increment's top bit never reach the phase, so the sum is kept modulo 2^56.
  assign prod    = PROD_SUM_BITS'(pp_lo_r) + (PROD_SUM_BITS'(pp_hi_r) << RATE_SPLIT);
  assign inc_nxt = prod[PROD_SUM_BITS-1 -: PHASE_BITS];

  always_ff @(posedge clk) begin
    if (ld.ld_freq) begin
      freq_r <= in_freq;
    end
    if (ld.ld_prod) begin
      pp_lo_r <= pp_lo_nxt;
      pp_hi_r <= pp_hi_nxt;
    end
    if (ld.ld_inc) begin
      inc_r <= inc_nxt;
    end
  end

endmodule

/* rtl/pao_shaper.sv */
// Waveform shaping: table lookup stage and output sample register.
// Depends on pao_pkg and pao_sine_rom.
`timescale 1ns / 1ps

module pao_shaper
  import pao_pkg::*;
(
  input  logic                          clk,
  input  pao_ld_t                       ld,
  input  logic [WAVE_BITS-1:0]          waveform,
  input  logic [PHASE_BITS-1:0]         phase,
  output logic signed [SAMPLE_BITS-1:0] out_sample
);

  logic [1:0]                 quad;
  logic [SINE_TABLE_BITS-1:0] idx;
  logic [ROM_ADDR_BITS-1:0]   rom_addr;
  logic [MAG_BITS-1:0]        mag_r;
  logic                       neg_r;
  logic                       half_r;
  logic [SAMPLE_BITS-1:0]     top_r;
  logic [WAVE_BITS-1:0]       wave_r;
  logic [SAMPLE_BITS-1:0]     mag_ext;
  logic [SAMPLE_BITS-1:0]     sample_nxt;
  logic [SAMPLE_BITS-1:0]     sample_r;

  assign quad = phase[PHASE_BITS-1 -: 2];
  assign idx  = phase[PHASE_BITS-3 -: SINE_TABLE_BITS];

  // Odd quadrants run the table backward; index zero there reads the last entry.
  assign rom_addr = quad[0] ? ROM_ADDR_BITS'(TABLE_N) - ROM_ADDR_BITS'(idx)
                            : ROM_ADDR_BITS'(idx);

  pao_sine_rom u_rom (
    .clk       (clk),
    .rd_en     (ld.ld_shape),
    .rd_addr   (rom_addr),
    .rd_data_r (mag_r)
  );

  always_ff @(posedge clk) begin
    if (ld.ld_shape) begin
      neg_r  <= quad[1];
      half_r <= phase[PHASE_BITS-1];
      top_r  <= phase[PHASE_BITS-1 -: SAMPLE_BITS];
      wave_r <= waveform;
    end
  end

  assign mag_ext = {1'b0, mag_r};

  always_comb begin
    case (wave_r)
      WAVE_SINE:  sample_nxt = neg_r ? (~mag_ext + 1'b1) : mag_ext;
      WAVE_SAW:   sample_nxt = {~top_r[SAMPLE_BITS-1], top_r[SAMPLE_BITS-2:0]};
      WAVE_PULSE: sample_nxt = half_r ? SAMPLE_NEG : SAMPLE_POS;
      default:    sample_nxt = neg_r ? (~mag_ext + 1'b1) : mag_ext;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld.ld_out) begin
      sample_r <= sample_nxt;
    end
  end

  assign out_sample = signed'(sample_r);

endmodule

/* rtl/phase_accumulator_oscillator.sv */
// Channel   Direction  Ports
// in        request in in_valid, in_stall, in_freq
// out       result out out_valid, out_stall, out_sample
// cfg       write in   cfg_we, cfg_index, cfg_wdata
//
// One request per cycle while the output is not stalled; each sample passes through the
// six-stage pipeline (input, partial products, sum, phase, table read, output).
// Synchronous reset zeroes phase and stage valid bits and resets the config registers.
// Each stage advances while the stage after it is empty or advancing, so bubbles close
// up and requests are taken while a finished sample waits; in_stall rises only when
// every stage holds an item and the output is stalled.
// Top level: configuration registers, phase accumulator and pipeline control.
// Depends on pao_pkg, pao_incr, pao_shaper and the assertion macro header.
`timescale 1ns / 1ps
`include "phase_accumulator_oscillator_assert.svh"

module phase_accumulator_oscillator
  import pao_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [FREQ_BITS-1:0]          in_freq,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_sample,
  input  logic                          cfg_we,
  input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_wdata
);

  logic [WAVE_BITS-1:0]  waveform_r;
  logic [RATE_BITS-1:0]  rate_scale_r;
  logic [PHASE_BITS-1:0] phase_r;
  logic [PHASE_BITS-1:0] inc_r;
  logic                  v1_r;
  logic                  v2_r;
  logic                  v3_r;
  logic                  v4_r;
  logic                  v5_r;
  logic                  out_valid_r;
  logic                  rdy1;
  logic                  rdy2;
  logic                  rdy3;
  logic                  rdy4;
  logic                  rdy5;
  logic                  rdy6;
  pao_ld_t               ld;

  assign rdy6 = !out_valid_r || !out_stall;
  assign rdy5 = !v5_r || rdy6;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign ld.ld_freq  = in_valid && rdy1;
  assign ld.ld_prod  = v1_r && rdy2;
  assign ld.ld_inc   = v2_r && rdy3;
  assign ld.ld_phase = v3_r && rdy4;
  assign ld.ld_shape = v4_r && rdy5;
  assign ld.ld_out   = v5_r && rdy6;

  assign in_stall  = !rdy1;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (rdy4) begin
        v4_r <= v3_r;
      end
      if (rdy5) begin
        v5_r <= v4_r;
      end
      if (rdy6) begin
        out_valid_r <= v5_r;
      end
    end
  end

  // A waveform write with the reserved code leaves the current shape in place.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waveform_r   <= WAVE_SINE;
      rate_scale_r <= RATE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WAVEFORM: begin
          if (cfg_wdata[WAVE_BITS-1:0] != WAVE_RESERVED) begin
            waveform_r <= cfg_wdata[WAVE_BITS-1:0];
          end
        end
        REG_RATE_SCALE: begin
          rate_scale_r <= cfg_wdata[RATE_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else if (ld.ld_phase) begin
      phase_r <= phase_r + inc_r;
    end
  end

  pao_incr u_incr (
    .clk        (clk),
    .ld         (ld),
    .in_freq    (in_freq),
    .rate_scale (rate_scale_r),
    .inc_r      (inc_r)
  );

  // The shaper samples phase_r while its item sits in the phase stage.
  pao_shaper u_shaper (
    .clk        (clk),
    .ld         (ld),
    .waveform   (waveform_r),
    .phase      (phase_r),
    .out_sample (out_sample)
  );

  `PAO_ASSERT_NEXT(a_phase_hold, !ld.ld_phase, $stable(phase_r))
  `PAO_ASSERT_IMPL(a_wave_legal, 1'b1, waveform_r != WAVE_RESERVED)
  `PAO_ASSERT_IMPL(a_stall_full, in_stall, v1_r && v2_r && v3_r && v4_r && v5_r && out_valid_r && out_stall)
  `PAO_ASSERT_NEXT(a_out_source, !out_valid_r && !v5_r, !out_valid_r)

endmodule
